// ===== rtl/core/lenient_utf8_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef LENIENT_UTF8_DECODER_TOP_MACROS_SVH
`define LENIENT_UTF8_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LUTF8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lutf8 same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define LUTF8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lutf8 next-cycle check failed");

`endif

// ===== rtl/core/lutf8_pkg.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder package
// Widths, datapath commands, status bundle and lead byte decode helpers.
// ----------------------------------------------------------------------------
package lutf8_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int CNT_W  = 3;   // window fill, 0 to 4
  localparam int LEN_W  = 3;   // sequence length, 0 (invalid) to 4
  localparam int WIN_D  = 4;   // three held bytes plus the new one

  // Datapath commands
  typedef logic [2:0] lutf8_op_t;
  localparam lutf8_op_t OP_NONE   = 3'd0;
  localparam lutf8_op_t OP_LOAD   = 3'd1;
  localparam lutf8_op_t OP_DROP   = 3'd2;
  localparam lutf8_op_t OP_EMIT   = 3'd3;
  localparam lutf8_op_t OP_FINISH = 3'd4;

  // Datapath status seen by the controller
  typedef struct packed {
    logic finish;     // head sequence incomplete or window empty
    logic emit;       // head sequence complete
    logic need_push;  // the next command loads the output register
    logic out_free;   // output register can take a new request
  } lutf8_stat_t;

  // Sequence length given by a lead byte, 0 for a byte that cannot lead
  function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    if ((b & 8'h80) == 8'h00) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Payload bits carried by a lead byte
  function automatic logic [6:0] lead_bits(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] m;
    if ((b & 8'h80) == 8'h00) begin
      m = b;
    end else if ((b & 8'hE0) == 8'hC0) begin
      m = b & 8'h1F;
    end else if ((b & 8'hF0) == 8'hE0) begin
      m = b & 8'h0F;
    end else begin
      m = b & 8'h07;
    end
    return m[6:0];
  endfunction

  function automatic logic is_cont(input logic [BYTE_W-1:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

endpackage

// ===== rtl/core/lutf8_in_if.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder input channel
// One string byte per request, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface lutf8_in_if
  import lutf8_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== rtl/core/lutf8_out_if.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder result channel
// One decoded code point, or an empty end marker, per request.
// ----------------------------------------------------------------------------
interface lutf8_out_if
  import lutf8_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            code_valid;
  logic            last_of_run;
  logic            string_done;

  modport source (output valid, output code_point, output code_valid,
                  output last_of_run, output string_done, input ready);
  modport sink   (input valid, input code_point, input code_valid,
                  input last_of_run, input string_done, output ready);
endinterface

// ===== rtl/core/lutf8_dpath.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder datapath
// Byte window, one-deep result holding stage and the output register.
// ----------------------------------------------------------------------------
module lutf8_dpath
  import lutf8_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lutf8_op_t         op,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              eos_in,
  output lutf8_stat_t       stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CP_W-1:0]   out_cp,
  output logic              out_cpv,
  output logic              out_last,
  output logic              out_done
);

  logic [BYTE_W-1:0] win_r [WIN_D];
  logic [BYTE_W-1:0] win_nxt [WIN_D];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              end_r, end_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [CP_W-1:0]   hold_cp_r, hold_cp_nxt;
  logic              ov_r, ov_nxt;
  logic [CP_W-1:0]   ocp_r, ocp_nxt;
  logic              ocpv_r, ocpv_nxt;
  logic              olast_r, olast_nxt;
  logic              odone_r, odone_nxt;

  logic [LEN_W-1:0]  len;
  logic [CP_W-1:0]   cp0, cp1, cp2, cp3, cp_sel;
  logic              c1, c2, c3;
  logic [CNT_W-1:0]  used;
  logic              finish, out_free;

  // Decode the head of the window
  always_comb begin
    len    = lead_len(win_r[0]);
    finish = (cnt_r == '0) || ((len != '0) && ({1'b0, len} > {1'b0, cnt_r}));
    c1     = (len >= 3'd2) && is_cont(win_r[1]);
    c2     = c1 && (len >= 3'd3) && is_cont(win_r[2]);
    c3     = c2 && (len == 3'd4) && is_cont(win_r[3]);
    cp0    = {{(CP_W-7){1'b0}}, lead_bits(win_r[0])};
    cp1    = {cp0[CP_W-7:0], win_r[1][5:0]};
    cp2    = {cp1[CP_W-7:0], win_r[2][5:0]};
    cp3    = {cp2[CP_W-7:0], win_r[3][5:0]};
    if (c3) begin
      cp_sel = cp3;
      used   = 3'd4;
    end else if (c2) begin
      cp_sel = cp2;
      used   = 3'd3;
    end else if (c1) begin
      cp_sel = cp1;
      used   = 3'd2;
    end else begin
      cp_sel = cp0;
      used   = 3'd1;
    end
  end

  assign out_free       = !ov_r || out_ready;
  assign stat.finish    = finish;
  assign stat.emit      = !finish && (len != '0);
  assign stat.need_push = finish ? (hold_v_r || end_r) : ((len != '0) && hold_v_r);
  assign stat.out_free  = out_free;

  // Apply the command
  always_comb begin
    for (int i = 0; i < WIN_D; i++) win_nxt[i] = win_r[i];
    cnt_nxt     = cnt_r;
    end_nxt     = end_r;
    hold_v_nxt  = hold_v_r;
    hold_cp_nxt = hold_cp_r;
    ov_nxt      = ov_r && !out_ready;
    ocp_nxt     = ocp_r;
    ocpv_nxt    = ocpv_r;
    olast_nxt   = olast_r;
    odone_nxt   = odone_r;
    unique case (op)
      OP_LOAD: begin
        win_nxt[cnt_r[1:0]] = byte_in;
        cnt_nxt             = cnt_r + 3'd1;
        end_nxt             = eos_in;
        hold_v_nxt          = 1'b0;
      end
      OP_DROP: begin
        for (int i = 0; i < WIN_D - 1; i++) win_nxt[i] = win_r[i+1];
        cnt_nxt = cnt_r - 3'd1;
      end
      OP_EMIT: begin
        // advance the window past the consumed bytes
        unique case (used)
          3'd1: for (int i = 0; i < WIN_D - 1; i++) win_nxt[i] = win_r[i+1];
          3'd2: for (int i = 0; i < WIN_D - 2; i++) win_nxt[i] = win_r[i+2];
          3'd3: win_nxt[0] = win_r[3];
          default: ;
        endcase
        cnt_nxt = cnt_r - used;
        if (hold_v_r) begin
          ov_nxt    = 1'b1;
          ocp_nxt   = hold_cp_r;
          ocpv_nxt  = 1'b1;
          olast_nxt = 1'b0;
          odone_nxt = 1'b0;
        end
        hold_v_nxt  = 1'b1;
        hold_cp_nxt = cp_sel;
      end
      OP_FINISH: begin
        if (hold_v_r) begin
          ov_nxt    = 1'b1;
          ocp_nxt   = hold_cp_r;
          ocpv_nxt  = 1'b1;
          olast_nxt = 1'b1;
          odone_nxt = end_r;
        end else if (end_r) begin
          ov_nxt    = 1'b1;
          ocp_nxt   = '0;
          ocpv_nxt  = 1'b0;
          olast_nxt = 1'b1;
          odone_nxt = 1'b1;
        end
        // drop leftovers at the end of a string
        if (end_r) cnt_nxt = '0;
        hold_v_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      end_r    <= 1'b0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      end_r    <= end_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_D; i++) win_r[i] <= win_nxt[i];
    hold_cp_r <= hold_cp_nxt;
    ocp_r     <= ocp_nxt;
    ocpv_r    <= ocpv_nxt;
    olast_r   <= olast_nxt;
    odone_r   <= odone_nxt;
  end

  assign out_valid = ov_r;
  assign out_cp    = ocp_r;
  assign out_cpv   = ocpv_r;
  assign out_last  = olast_r;
  assign out_done  = odone_r;

endmodule

// ===== rtl/core/lutf8_ctrl.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder controller
// Accepts a byte, then walks the window one sequence or dropped byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module lutf8_ctrl
  import lutf8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lutf8_stat_t stat,
  output lutf8_op_t   op
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic stall;

  // Hold while a push would overwrite an untaken request
  assign stall = stat.need_push && !stat.out_free;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        priority if (stall) begin
          op = OP_NONE;
        end else if (stat.finish) begin
          op        = OP_FINISH;
          state_nxt = ST_IDLE;
        end else if (stat.emit) begin
          op = OP_EMIT;
        end else begin
          op = OP_DROP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/lenient_utf8_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder top level
// Turns a UTF-8 byte stream into code points, tolerating malformed input.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one byte per request, end_of_string set on the last one.
//   out_chan carries code points; last_of_run marks the last request caused
//   by a byte, string_done the last one of a string. A string that yields no
//   code point on its final byte still gives one request with code_valid 0.
// Flow:
//   A byte goes through an accept step, one step per dropped byte or decoded
//   sequence in the window and a closing step; a needed push into a full
//   output register pauses the walk, which the controller runs; in_ready is
//   high only between bytes. A decoded code point waits in the holding stage
//   until the next emit or closing step moves it into the output register.
// Reset:
//   Synchronous, active low; empties the byte window and the output register.
// Backpressure:
//   A finished request waits in the output register while the next byte is
//   accepted; the window walk pauses only when it must push a further request.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder_top
  import lutf8_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  lutf8_in_if.sink    in_chan,
  lutf8_out_if.source out_chan
);

  lutf8_op_t   op;
  lutf8_stat_t stat;

  lutf8_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .op       (op)
  );

  lutf8_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .byte_in   (in_chan.in_byte),
    .eos_in    (in_chan.end_of_string),
    .stat      (stat),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_cp    (out_chan.code_point),
    .out_cpv   (out_chan.code_valid),
    .out_last  (out_chan.last_of_run),
    .out_done  (out_chan.string_done)
  );

endmodule

// ===== rtl/core/lutf8_checker.sv =====
// ----------------------------------------------------------------------------
// Lenient UTF-8 decoder port checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "lenient_utf8_decoder_top_macros.svh"

module lutf8_checker
  import lutf8_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CP_W-1:0] code_point,
  input logic            code_valid,
  input logic            last_of_run,
  input logic            string_done
);

  // A stalled request holds
  `LUTF8_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(last_of_run))

  // An empty request only closes a string
  `LUTF8_ASSERT_NOW(a_empty_closes, clk, rst_n, out_valid && !code_valid, last_of_run && string_done && (code_point == '0))

  // The end of a string is also the end of its byte's run
  `LUTF8_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid && string_done, last_of_run)

  // One byte at a time: the window walk follows every accept
  `LUTF8_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind lenient_utf8_decoder_top lutf8_checker u_lutf8_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .code_point  (out_chan.code_point),
  .code_valid  (out_chan.code_valid),
  .last_of_run (out_chan.last_of_run),
  .string_done (out_chan.string_done)
);
